// ===== sv/sict_pkg.sv =====
// Shared types and constants for the stacking item count table.
`default_nettype none
package sict_pkg;

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 31;
  localparam int REQ_W   = 2;
  localparam int USED_W  = 5;
  localparam int LIMIT_W = 5;
  localparam int ENTRY_W = KEY_W + CNT_W;

  localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [LIMIT_W-1:0] MAX_SLOTS_RST = LIMIT_W'(16);

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_NEW      = 3'd1,
    ST_REDUCED  = 3'd2,
    ST_FREED    = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_INVALID  = 3'd5,
    ST_FULL     = 3'd6,
    ST_NOTFOUND = 3'd7
  } status_t;

  // Count update computed for a matching entry.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             freed;
  } upd_t;

endpackage
`default_nettype wire

// ===== sv/sict_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface sict_in_if import sict_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] item_key;
  logic [CNT_W-1:0] amount;

  modport source (output valid, req_type, item_key, amount, input ready);
  modport sink   (input valid, req_type, item_key, amount, output ready);
endinterface

interface sict_out_if import sict_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              changed;
  logic [CNT_W-1:0]  entry_count;
  logic [USED_W-1:0] used_slots;

  modport source (output valid, status, changed, entry_count, used_slots, input ready);
  modport sink   (input valid, status, changed, entry_count, used_slots, output ready);
endinterface
`default_nettype wire

// ===== sv/stacking_item_count_table_top.sv =====
// Keyed counter table: ordered entries in one memory, searched and compacted serially.
//
//   channel   dir   handshake           payload
//   in_ch     in    valid/ready         req_type, item_key, amount
//   out_ch    out   valid/ready         status, changed, entry_count, used_slots
//   cfg       in    cfg_we              cfg_wdata (max_slots)
//
// Clear and invalid go from idle straight to the result state; other requests scan
// the entries one by one, then take the miss state on a miss or shift each later entry
// down one place when one is freed. The single read port of the entry memory sets this.
// Reset empties the table at once; entry contents stay undefined until written.
// A result waits in the output register; a new request is taken as soon as the
// previous result has moved there, while out_ch may still be stalled.
`default_nettype none
module stacking_item_count_table_top import sict_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  sict_in_if.sink             in_ch,
  sict_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam int CMP_W = OCC_W + 1;
  localparam int LIM_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MISS,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t               state_r;
  logic [OCC_W-1:0]     occupied_r;
  logic [LIMIT_W-1:0]   max_slots_r;
  logic [IDX_W-1:0]     scan_r;
  logic [REQ_W-1:0]     req_r;
  logic [KEY_W-1:0]     key_r;
  logic [CNT_W-1:0]     amt_r;
  status_t              res_status_r;
  logic                 res_changed_r;
  logic [CNT_W-1:0]     res_count_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_changed_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [USED_W-1:0]    out_used_r;

  logic [ENTRY_W-1:0]   mem [SLOTS];
  logic [ENTRY_W-1:0]   rdata_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  logic [KEY_W-1:0]     rd_key;
  logic [CNT_W-1:0]     rd_count;
  logic                 in_fire;
  logic                 out_free;
  logic                 is_add;
  logic                 hit;
  logic                 last;
  logic                 shift_last;
  logic                 full;
  logic [LIM_W-1:0]     limit;
  upd_t                 upd;

  assign rd_key   = rdata_r[ENTRY_W-1:CNT_W];
  assign rd_count = rdata_r[CNT_W-1:0];
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_add   = (req_r == REQ_ADD);
  assign hit      = (rd_key == key_r);
  assign last       = (CMP_W'(scan_r) + CMP_W'(1)) == CMP_W'(occupied_r);
  assign shift_last = (CMP_W'(scan_r) + CMP_W'(2)) == CMP_W'(occupied_r);
  assign limit    = (LIM_W'(max_slots_r) < LIM_W'(SLOTS)) ? LIM_W'(max_slots_r)
                                                          : LIM_W'(SLOTS);
  assign full     = LIM_W'(occupied_r) >= limit;

  sict_upd u_upd (
    .is_add (is_add),
    .count  (rd_count),
    .amount (amt_r),
    .upd    (upd)
  );

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_r;
    mem_wdata = {key_r, upd.count};
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        mem_raddr = '0;
      end
      S_SEARCH: begin
        mem_raddr = IDX_W'(CMP_W'(scan_r) + CMP_W'(1));
        mem_we    = hit && (is_add || !upd.freed);
      end
      S_MISS: begin
        mem_waddr = IDX_W'(occupied_r);
        mem_wdata = {key_r, amt_r};
        mem_we    = is_add && !full;
      end
      S_SHIFT: begin
        // move the entry above down one place
        mem_raddr = IDX_W'(CMP_W'(scan_r) + CMP_W'(2));
        mem_wdata = rdata_r;
        mem_we    = 1'b1;
      end
      S_RESP: begin
        mem_raddr = '0;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occupied_r  <= '0;
      max_slots_r <= MAX_SLOTS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_slots_r <= cfg_wdata;
      end

      if (state_r == S_RESP && out_free) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= res_status_r;
        out_changed_r <= res_changed_r;
        out_count_r   <= res_count_r;
        out_used_r    <= USED_W'(occupied_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r  <= in_ch.req_type;
            key_r  <= in_ch.item_key;
            amt_r  <= in_ch.amount;
            scan_r <= '0;
            priority if (in_ch.req_type == REQ_CLEAR) begin
              occupied_r    <= '0;
              res_status_r  <= ST_CLEARED;
              res_changed_r <= 1'b1;
              res_count_r   <= '0;
              state_r       <= S_RESP;
            end else if ((in_ch.req_type != REQ_ADD && in_ch.req_type != REQ_REMOVE)
                         || in_ch.item_key == '0 || in_ch.amount == '0) begin
              res_status_r  <= ST_INVALID;
              res_changed_r <= 1'b0;
              res_count_r   <= '0;
              state_r       <= S_RESP;
            end else if (occupied_r == '0) begin
              state_r <= S_MISS;
            end else begin
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          priority if (hit) begin
            res_changed_r <= 1'b1;
            priority if (is_add) begin
              res_status_r <= ST_MERGED;
              res_count_r  <= upd.count;
              state_r      <= S_RESP;
            end else if (upd.freed) begin
              res_status_r <= ST_FREED;
              res_count_r  <= '0;
              if (last) begin
                occupied_r <= occupied_r - OCC_W'(1);
                state_r    <= S_RESP;
              end else begin
                state_r <= S_SHIFT;
              end
            end else begin
              res_status_r <= ST_REDUCED;
              res_count_r  <= upd.count;
              state_r      <= S_RESP;
            end
          end else if (last) begin
            state_r <= S_MISS;
          end else begin
            scan_r <= scan_r + IDX_W'(1);
          end
        end
        S_MISS: begin
          priority if (!is_add) begin
            res_status_r  <= ST_NOTFOUND;
            res_changed_r <= 1'b0;
            res_count_r   <= '0;
          end else if (full) begin
            res_status_r  <= ST_FULL;
            res_changed_r <= 1'b0;
            res_count_r   <= '0;
          end else begin
            res_status_r  <= ST_NEW;
            res_changed_r <= 1'b1;
            res_count_r   <= amt_r;
            occupied_r    <= occupied_r + OCC_W'(1);
          end
          state_r <= S_RESP;
        end
        S_SHIFT: begin
          if (shift_last) begin
            occupied_r <= occupied_r - OCC_W'(1);
            state_r    <= S_RESP;
          end else begin
            scan_r <= scan_r + IDX_W'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.changed     = out_changed_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.used_slots  = out_used_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(occupied_r) <= CMP_W'(SLOTS))
    else $error("occupied slot count exceeds table size");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("pending result not moved to output register");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.req_type == REQ_CLEAR) |=>
      (occupied_r == '0 && res_status_r == ST_CLEARED && state_r == S_RESP))
    else $error("clear request did not empty the table");

endmodule
`default_nettype wire

// ===== sv/sict_upd.sv =====
// Count arithmetic for a matching entry: saturating add, or subtract with free check.
`default_nettype none
module sict_upd import sict_pkg::*; (
  input  logic             is_add,
  input  logic [CNT_W-1:0] count,
  input  logic [CNT_W-1:0] amount,
  output upd_t             upd
);

  logic [CNT_W:0] sum;
  logic [CNT_W:0] diff;

  assign sum  = {1'b0, count} + {1'b0, amount};
  assign diff = {1'b0, count} - {1'b0, amount};

  always_comb begin
    if (is_add) begin
      // saturate when the sum spills past the count range
      upd.count = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
      upd.freed = 1'b0;
    end else begin
      // borrow or zero result means the entry goes away
      upd.freed = diff[CNT_W] || (diff[CNT_W-1:0] == '0);
      upd.count = diff[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== verif/stacking_item_count_table_top_tb.sv =====
// Self-checking testbench for the keyed item count table: directed rows, then random traffic.
`timescale 1ns / 100ps

module stacking_item_count_table_top_tb;
  import sict_pkg::*;

  localparam int SLOTS      = 16;
  localparam int DIR_N      = 23;
  localparam int PHASES     = 8;
  localparam int PHASE_N    = 90;
  localparam int POOL_N     = 24;
  localparam int LONG_HOLD  = 120;
  localparam int TIMEOUT_NS = 10_000_000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    status_t           status;
    logic              changed;
    logic [CNT_W-1:0]  entry_count;
    logic [USED_W-1:0] used_slots;
  } reply_t;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] amt;
    bit               chk;
    reply_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  sict_in_if  in_ch ();
  sict_out_if out_ch ();

  stacking_item_count_table_top #(.SLOTS(SLOTS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Mirror of the table contents and the slot limit register.
  logic [KEY_W-1:0]   slot_key [SLOTS];
  logic [CNT_W-1:0]   slot_cnt [SLOTS];
  int                 used_now = 0;
  logic [LIMIT_W-1:0] slot_limit = MAX_SLOTS_RST;

  reply_t     replies_due [$];
  int         errors = 0;
  int         words_sent = 0;
  int         replies_seen = 0;
  int         status_seen [8];
  bit         calm = 1'b0;
  bit         stall_long = 1'b0;
  logic [KEY_W-1:0] key_pool [POOL_N];
  dir_row_t   dir_rows [DIR_N];
  logic [LIMIT_W-1:0] phase_limit [PHASES] =
    '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd16};

  // Apply one request to the mirrored table and return the reply it owes.
  function automatic reply_t table_apply(input logic [REQ_W-1:0] req,
                                         input logic [KEY_W-1:0] key,
                                         input logic [CNT_W-1:0] amt);
    reply_t r;
    int at;
    int cap;
    int i;
    logic [CNT_W:0] sum;
    r.status = ST_INVALID;
    r.changed = 1'b0;
    r.entry_count = '0;
    at = used_now;
    for (i = used_now - 1; i >= 0; i--) begin
      if (slot_key[i] == key) at = i;
    end
    if (req == REQ_CLEAR) begin
      used_now = 0;
      r.status = ST_CLEARED;
      r.changed = 1'b1;
    end else if ((req == REQ_ADD || req == REQ_REMOVE) && key != '0 && amt != '0) begin
      if (req == REQ_ADD) begin
        if (at < used_now) begin
          sum = {1'b0, slot_cnt[at]} + {1'b0, amt};
          slot_cnt[at] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
          r.status = ST_MERGED;
          r.changed = 1'b1;
          r.entry_count = slot_cnt[at];
        end else begin
          cap = (int'(slot_limit) < SLOTS) ? int'(slot_limit) : SLOTS;
          if (used_now >= cap) begin
            r.status = ST_FULL;
          end else begin
            slot_key[used_now] = key;
            slot_cnt[used_now] = amt;
            used_now++;
            r.status = ST_NEW;
            r.changed = 1'b1;
            r.entry_count = amt;
          end
        end
      end else if (at >= used_now) begin
        r.status = ST_NOTFOUND;
      end else if (amt >= slot_cnt[at]) begin
        // close the gap, keep insertion order
        for (i = at; i + 1 < used_now; i++) begin
          slot_key[i] = slot_key[i + 1];
          slot_cnt[i] = slot_cnt[i + 1];
        end
        used_now--;
        r.status = ST_FREED;
        r.changed = 1'b1;
      end else begin
        slot_cnt[at] = slot_cnt[at] - amt;
        r.status = ST_REDUCED;
        r.changed = 1'b1;
        r.entry_count = slot_cnt[at];
      end
    end
    r.used_slots = USED_W'(used_now);
    return r;
  endfunction

  // Offer one word; a typed reply replaces the mirror's when chk is set.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                           input logic [CNT_W-1:0] amt, input bit chk, input reply_t typed);
    reply_t due;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.req_type = req;
    in_ch.item_key = key;
    in_ch.amount   = amt;
    in_ch.valid    = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = table_apply(req, key, amt);
    if (chk) due = typed;
    replies_due.push_back(due);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_replies();
    while (replies_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    in_ch.valid = 1'b0;
    wait_replies();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    slot_limit = v;
  endtask

  task automatic send_random();
    int pick;
    int at;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] amt;
    logic [CNT_W-1:0] have;
    reply_t none;
    none = '{ST_INVALID, 1'b0, '0, '0};
    pick = $urandom_range(0, 99);
    key = key_pool[$urandom_range(0, POOL_N - 1)];
    case ($urandom_range(0, 9))
      0:       amt = CNT_MAX;
      1:       amt = CNT_W'($urandom);
      default: amt = CNT_W'($urandom_range(1, 50));
    endcase
    if (pick < 46) begin
      req = REQ_ADD;
    end else if (pick < 82) begin
      req = REQ_REMOVE;
      // mostly aim at a live entry so the reduce and free paths get exercised
      if (used_now != 0 && $urandom_range(0, 3) != 0) begin
        at = $urandom_range(0, used_now - 1);
        key = slot_key[at];
        have = slot_cnt[at];
        case ($urandom_range(0, 3))
          0:       amt = have;
          1:       amt = CNT_MAX;
          default: amt = (have > 1) ? CNT_W'($urandom_range(1, have - 1)) : have;
        endcase
      end
    end else if (pick < 85) begin
      req = REQ_CLEAR;
    end else begin
      req = $urandom_range(0, 1) ? REQ_ADD : REQ_REMOVE;
      case ($urandom_range(0, 2))
        0:       key = '0;
        1:       amt = '0;
        default: req = REQ_UNUSED;
      endcase
    end
    send_word(req, key, amt, 1'b0, none);
  endtask

  // Result side: random stall bursts, one long hold-off on request.
  initial begin : reply_side
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        stall_long = 1'b0;
        out_ch.ready = 1'b0;
        for (n = 1; n < LONG_HOLD; n++) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      replies_seen++;
      status_seen[out_ch.status]++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply status=%0d changed=%0d count=%0h used=%0d", $time,
                 out_ch.status, out_ch.changed, out_ch.entry_count, out_ch.used_slots);
      end else begin
        want = replies_due.pop_front();
        if (out_ch.status !== want.status || out_ch.changed !== want.changed ||
            out_ch.entry_count !== want.entry_count || out_ch.used_slots !== want.used_slots) begin
          errors++;
          $display("%0t: mismatch expected status=%0d changed=%0d count=%0h used=%0d", $time,
                   want.status, want.changed, want.entry_count, want.used_slots);
          $display("%0t:          actual   status=%0d changed=%0d count=%0h used=%0d", $time,
                   out_ch.status, out_ch.changed, out_ch.entry_count, out_ch.used_slots);
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int k;
    int p;
    int n;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_ADD;
    in_ch.item_key = '0;
    in_ch.amount   = '0;
    for (k = 0; k < 8; k++) status_seen[k] = 0;
    for (k = 0; k < SLOTS; k++) begin
      slot_key[k] = '0;
      slot_cnt[k] = '0;
    end
    dir_rows = '{
      '{REQ_CLEAR,  32'h0,         31'h0,         1'b1, '{ST_CLEARED,  1'b1, 31'h0, 5'd0}},
      '{REQ_ADD,    32'h0,         31'd5,         1'b1, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_ADD,    32'd5,         31'h0,         1'b1, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_UNUSED, 32'd1,         31'd1,         1'b1, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_REMOVE, 32'd7,         31'd1,         1'b1, '{ST_NOTFOUND, 1'b0, 31'h0, 5'd0}},
      '{REQ_ADD,    32'hFFFFFFFF,  31'd1,         1'b1, '{ST_NEW,      1'b1, 31'd1, 5'd1}},
      '{REQ_ADD,    32'hFFFFFFFF,  CNT_MAX,       1'b1, '{ST_MERGED,   1'b1, CNT_MAX, 5'd1}},
      '{REQ_ADD,    32'hFFFFFFFF,  31'd1,         1'b1, '{ST_MERGED,   1'b1, CNT_MAX, 5'd1}},
      '{REQ_ADD,    32'd1,         CNT_MAX,       1'b1, '{ST_NEW,      1'b1, CNT_MAX, 5'd2}},
      '{REQ_ADD,    32'd2,         31'd100,       1'b1, '{ST_NEW,      1'b1, 31'd100, 5'd3}},
      '{REQ_REMOVE, 32'd1,         31'd5,         1'b0, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_REMOVE, 32'hFFFFFFFF,  CNT_MAX,       1'b1, '{ST_FREED,    1'b1, 31'h0, 5'd2}},
      '{REQ_REMOVE, 32'd2,         31'd40,        1'b0, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_ADD,    32'd2,         31'd1,         1'b0, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_REMOVE, 32'd2,         CNT_MAX,       1'b1, '{ST_FREED,    1'b1, 31'h0, 5'd1}},
      '{REQ_REMOVE, 32'd1,         31'h0,         1'b1, '{ST_INVALID,  1'b0, 31'h0, 5'd1}},
      '{REQ_REMOVE, 32'h0,         31'd3,         1'b1, '{ST_INVALID,  1'b0, 31'h0, 5'd1}},
      '{REQ_UNUSED, 32'hFFFFFFFF,  CNT_MAX,       1'b1, '{ST_INVALID,  1'b0, 31'h0, 5'd1}},
      '{REQ_ADD,    32'hAAAAAAAA,  31'h55555555,  1'b0, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_ADD,    32'h55555555,  31'h2AAAAAAA,  1'b0, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_REMOVE, 32'hAAAAAAAA,  31'h55555556,  1'b1, '{ST_FREED,    1'b1, 31'h0, 5'd2}},
      '{REQ_REMOVE, 32'h55555555,  31'd1,         1'b0, '{ST_INVALID,  1'b0, 31'h0, 5'd0}},
      '{REQ_CLEAR,  32'h12345678,  31'h07654321,  1'b1, '{ST_CLEARED,  1'b1, 31'h0, 5'd0}}
    };

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (k = 0; k < DIR_N; k++)
      send_word(dir_rows[k].req, dir_rows[k].key, dir_rows[k].amt, dir_rows[k].chk,
                dir_rows[k].want);

    for (p = 0; p < PHASES; p++) begin
      set_limit(phase_limit[p]);
      if (p == PHASES - 1) calm = 1'b1;
      key_pool[0] = 32'd1;
      key_pool[1] = 32'hFFFFFFFF;
      for (k = 2; k < POOL_N; k++) key_pool[k] = $urandom;
      for (n = 0; n < PHASE_N; n++) begin
        // hold the result side off while words keep coming
        if (p == 1 && n == 10) stall_long = 1'b1;
        if (p == 3 && n == PHASE_N / 2) begin
          in_ch.valid = 1'b0;
          wait_replies();
        end
        send_random();
      end
    end

    in_ch.valid = 1'b0;
    wait_replies();
    repeat (2 * SLOTS + 8) @(posedge clk);

    $display("Sent %0d requests over %0d slot limits, incl. a long result stall; %0d replies.",
             words_sent, PHASES + 1, replies_seen);
    $display("Replies by status merged/new/reduced/freed/cleared/invalid/full/absent: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
